// ----- hw/rtl/affine_point_transform_core_macros.svh -----
// Assertion macros used by the checker of the affine transform core.
`ifndef AFFINE_POINT_TRANSFORM_CORE_MACROS_SVH
`define AFFINE_POINT_TRANSFORM_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define APT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define APT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/apt_pkg.sv -----
package apt_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int CFG_IDX_W       = 3;

    localparam logic [1:0] CMD_POINT     = 2'd0;
    localparam logic [1:0] CMD_DIST      = 2'd1;
    localparam logic [1:0] CMD_INV_POINT = 2'd2;
    localparam logic [1:0] CMD_INV_DIST  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SINGULAR = 2'd1;
    localparam logic [1:0] ST_SAT      = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_XX = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_YX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_XY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_YY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y = 3'd5;

    // front end -> prep
    typedef struct packed {
        logic valid;
        logic inv;
    } front_t;

    // control that rides along the divider pipeline
    typedef struct packed {
        logic valid;
        logic singular;
        logic neg_x;
        logic neg_y;
        logic ovf_x;
        logic ovf_y;
    } ctl_t;

    // signed width of the exact numerators
    function automatic int sum_width(input int w, input int f);
        return ((2 * w > w + f) ? 2 * w : w + f) + 3;
    endfunction

    // signed width of the determinant, also the width of its magnitude
    function automatic int den_width(input int w);
        return 2 * w + 1;
    endfunction

    // partial remainder width of the divider
    function automatic int rem_width(input int w, input int f);
        return (sum_width(w, f) + f + 1 > den_width(w) + w + 1) ?
               sum_width(w, f) + f + 1 : den_width(w) + w + 1;
    endfunction

endpackage

// ----- hw/rtl/affine_point_transform_core.sv -----
// Channel | Direction | Handshake          | Word
// in      | into core | in_valid/in_stall   | command, x_in, y_in
// out     | from core | out_valid/out_stall | x_out, y_out, status
// cfg     | into core | cfg_we              | cfg_index, cfg_data
//
// One word per cycle in and out while the result word is not stalled; the
// restoring divider takes one quotient bit per stage, COORD_WIDTH + 1 stages.
// rst_n clears all valid bits and loads the identity matrix, zero shift.
// A stalled output word freezes the whole pipeline; in_stall is raised only
// while out_valid and out_stall are both high, so nothing is lost or repeated.
module affine_point_transform_core #(
    parameter int FRAC_BITS   = apt_pkg::FRAC_BITS_DEF,
    parameter int COORD_WIDTH = apt_pkg::COORD_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input word channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      command,
    input  logic signed [COORD_WIDTH-1:0]   x_in,
    input  logic signed [COORD_WIDTH-1:0]   y_in,
    // result word channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [COORD_WIDTH-1:0]   x_out,
    output logic signed [COORD_WIDTH-1:0]   y_out,
    output logic [1:0]                      status,
    // register write port
    input  logic                            cfg_we,
    input  logic [apt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [COORD_WIDTH-1:0]          cfg_data
);

    localparam int W  = COORD_WIDTH;
    localparam int SW = apt_pkg::sum_width(W, FRAC_BITS);
    localparam int DB = apt_pkg::den_width(W);
    localparam int DW = apt_pkg::rem_width(W, FRAC_BITS);
    localparam int NSTEP = W + 1;
    localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;

    // matrix registers
    logic signed [W-1:0] coef_xx_reg, coef_yx_reg, coef_xy_reg, coef_yy_reg;
    logic signed [W-1:0] shift_x_reg, shift_y_reg;

    // global advance: hold every pipeline stage while the output word is stalled
    logic en;

    apt_pkg::front_t      front;
    logic signed [SW-1:0] sum_x, sum_y;
    logic signed [DB-1:0] det;

    // divider pipeline taps, index 0 is the prep output
    apt_pkg::ctl_t ctl_s  [0:NSTEP];
    logic [DB-1:0] den_s  [0:NSTEP];
    logic [DW-1:0] remx_s [0:NSTEP];
    logic [DW-1:0] remy_s [0:NSTEP];
    logic [W:0]    qx_s   [0:NSTEP];
    logic [W:0]    qy_s   [0:NSTEP];

    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_xx_reg <= ONE;
            coef_yx_reg <= '0;
            coef_xy_reg <= '0;
            coef_yy_reg <= ONE;
            shift_x_reg <= '0;
            shift_y_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                apt_pkg::REG_COEF_XX: coef_xx_reg <= cfg_data;
                apt_pkg::REG_COEF_YX: coef_yx_reg <= cfg_data;
                apt_pkg::REG_COEF_XY: coef_xy_reg <= cfg_data;
                apt_pkg::REG_COEF_YY: coef_yy_reg <= cfg_data;
                apt_pkg::REG_SHIFT_X: shift_x_reg <= cfg_data;
                apt_pkg::REG_SHIFT_Y: shift_y_reg <= cfg_data;
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // stages 1-3: exact numerators and determinant
    apt_mac #(
        .FRAC_BITS   (FRAC_BITS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .command  (command),
        .x_in     (x_in),
        .y_in     (y_in),
        .coef_xx  (coef_xx_reg),
        .coef_yx  (coef_yx_reg),
        .coef_xy  (coef_xy_reg),
        .coef_yy  (coef_yy_reg),
        .shift_x  (shift_x_reg),
        .shift_y  (shift_y_reg),
        .front    (front),
        .sum_x    (sum_x),
        .sum_y    (sum_y),
        .det      (det)
    );

    // stages 4-5: signs, magnitudes, forward rounding, quotient range check
    apt_prep #(
        .FRAC_BITS   (FRAC_BITS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_prep (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .front   (front),
        .sum_x   (sum_x),
        .sum_y   (sum_y),
        .det     (det),
        .ctl_o   (ctl_s[0]),
        .den_o   (den_s[0]),
        .rem_x_o (remx_s[0]),
        .rem_y_o (remy_s[0]),
        .q_x_o   (qx_s[0]),
        .q_y_o   (qy_s[0])
    );

    // divider: quotient bits MSB first, one per stage; forward words pass
    // through untouched (zero remainder never meets the trial divisor)
    for (genvar g = 0; g < NSTEP; g++)
    begin : g_div
        apt_div_step #(
            .FRAC_BITS   (FRAC_BITS),
            .COORD_WIDTH (COORD_WIDTH),
            .STEP        (W - g)
        ) u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .ctl_i   (ctl_s[g]),
            .den_i   (den_s[g]),
            .rem_x_i (remx_s[g]),
            .rem_y_i (remy_s[g]),
            .q_x_i   (qx_s[g]),
            .q_y_i   (qy_s[g]),
            .ctl_o   (ctl_s[g+1]),
            .den_o   (den_s[g+1]),
            .rem_x_o (remx_s[g+1]),
            .rem_y_o (remy_s[g+1]),
            .q_x_o   (qx_s[g+1]),
            .q_y_o   (qy_s[g+1])
        );
    end

    // final rounding, clamp and output register
    apt_finish #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .ctl_i     (ctl_s[NSTEP]),
        .q_x_i     (qx_s[NSTEP]),
        .q_y_i     (qy_s[NSTEP]),
        .out_valid (out_valid),
        .x_out     (x_out),
        .y_out     (y_out),
        .status    (status)
    );

endmodule

// ----- hw/rtl/apt_mac.sv -----
// Stages 1-3: translation removal, products, exact sums and determinant.
module apt_mac #(
    parameter int FRAC_BITS   = apt_pkg::FRAC_BITS_DEF,
    parameter int COORD_WIDTH = apt_pkg::COORD_WIDTH_DEF
) (
    input  logic                                                    clk,
    input  logic                                                    rst_n,
    input  logic                                                    en,
    input  logic                                                    in_valid,
    input  logic [1:0]                                              command,
    input  logic signed [COORD_WIDTH-1:0]                           x_in,
    input  logic signed [COORD_WIDTH-1:0]                           y_in,
    input  logic signed [COORD_WIDTH-1:0]                           coef_xx,
    input  logic signed [COORD_WIDTH-1:0]                           coef_yx,
    input  logic signed [COORD_WIDTH-1:0]                           coef_xy,
    input  logic signed [COORD_WIDTH-1:0]                           coef_yy,
    input  logic signed [COORD_WIDTH-1:0]                           shift_x,
    input  logic signed [COORD_WIDTH-1:0]                           shift_y,
    output apt_pkg::front_t                                         front,
    output logic signed [apt_pkg::sum_width(COORD_WIDTH, FRAC_BITS)-1:0] sum_x,
    output logic signed [apt_pkg::sum_width(COORD_WIDTH, FRAC_BITS)-1:0] sum_y,
    output logic signed [apt_pkg::den_width(COORD_WIDTH)-1:0]       det
);

    localparam int W   = COORD_WIDTH;
    localparam int UW  = W + 1;
    localparam int PW  = 2 * W + 1;
    localparam int DPW = 2 * W;
    localparam int SW  = apt_pkg::sum_width(W, FRAC_BITS);
    localparam int DTW = apt_pkg::den_width(W);

    // stage 1
    logic                 v1_reg;
    logic [1:0]           cmd1_reg;
    logic signed [UW-1:0] ux_reg, ux_next;
    logic signed [UW-1:0] uy_reg, uy_next;

    // stage 2
    logic                  v2_reg;
    logic [1:0]            cmd2_reg;
    logic signed [PW-1:0]  p0_reg, p1_reg, p2_reg, p3_reg;
    logic signed [PW-1:0]  p0_next, p1_next, p2_next, p3_next;
    logic signed [DPW-1:0] pd0_reg, pd1_reg, pd0_next, pd1_next;
    logic                  inv2;
    logic signed [W-1:0]   m0a, m2a, m3a;
    logic signed [UW-1:0]  m2b, m3b;

    // stage 3
    logic                  v3_reg;
    logic                  inv3_reg;
    logic signed [SW-1:0]  sx_reg, sx_next;
    logic signed [SW-1:0]  sy_reg, sy_next;
    logic signed [DTW-1:0] det_reg, det_next;
    logic                  inv_c2;
    logic                  pnt_c2;
    logic signed [SW-1:0]  tx_term, ty_term;

    always_comb
    begin
        if (command == apt_pkg::CMD_INV_POINT)
        begin
            ux_next = UW'(x_in) - UW'(shift_x);
            uy_next = UW'(y_in) - UW'(shift_y);
        end
        else
        begin
            ux_next = UW'(x_in);
            uy_next = UW'(y_in);
        end
    end

    // forward: a*x, c*y, b*x, d*y; inverse: d*x, c*y, a*y, b*x
    assign inv2 = (cmd1_reg == apt_pkg::CMD_INV_POINT) || (cmd1_reg == apt_pkg::CMD_INV_DIST);
    assign m0a  = inv2 ? coef_yy : coef_xx;
    assign m2a  = inv2 ? coef_xx : coef_yx;
    assign m2b  = inv2 ? uy_reg  : ux_reg;
    assign m3a  = inv2 ? coef_yx : coef_yy;
    assign m3b  = inv2 ? ux_reg  : uy_reg;

    always_comb
    begin
        p0_next  = PW'(m0a) * PW'(ux_reg);
        p1_next  = PW'(coef_xy) * PW'(uy_reg);
        p2_next  = PW'(m2a) * PW'(m2b);
        p3_next  = PW'(m3a) * PW'(m3b);
        pd0_next = DPW'(coef_xx) * DPW'(coef_yy);
        pd1_next = DPW'(coef_yx) * DPW'(coef_xy);
    end

    assign inv_c2  = (cmd2_reg == apt_pkg::CMD_INV_POINT) || (cmd2_reg == apt_pkg::CMD_INV_DIST);
    assign pnt_c2  = (cmd2_reg == apt_pkg::CMD_POINT);
    assign tx_term = pnt_c2 ? (SW'(shift_x) <<< FRAC_BITS) : '0;
    assign ty_term = pnt_c2 ? (SW'(shift_y) <<< FRAC_BITS) : '0;

    always_comb
    begin
        if (inv_c2)
        begin
            sx_next = SW'(p0_reg) - SW'(p1_reg);
            sy_next = SW'(p2_reg) - SW'(p3_reg);
        end
        else
        begin
            sx_next = SW'(p0_reg) + SW'(p1_reg) + tx_term;
            sy_next = SW'(p2_reg) + SW'(p3_reg) + ty_term;
        end
        det_next = DTW'(pd0_reg) - DTW'(pd1_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd1_reg <= command;
            ux_reg   <= ux_next;
            uy_reg   <= uy_next;
            cmd2_reg <= cmd1_reg;
            p0_reg   <= p0_next;
            p1_reg   <= p1_next;
            p2_reg   <= p2_next;
            p3_reg   <= p3_next;
            pd0_reg  <= pd0_next;
            pd1_reg  <= pd1_next;
            inv3_reg <= inv_c2;
            sx_reg   <= sx_next;
            sy_reg   <= sy_next;
            det_reg  <= det_next;
        end
    end

    assign front.valid = v3_reg;
    assign front.inv   = inv3_reg;
    assign sum_x       = sx_reg;
    assign sum_y       = sy_reg;
    assign det         = det_reg;

endmodule

// ----- hw/rtl/apt_prep.sv -----
// Stages 4-5: magnitudes and signs, forward rounding, divider setup.
module apt_prep #(
    parameter int FRAC_BITS   = apt_pkg::FRAC_BITS_DEF,
    parameter int COORD_WIDTH = apt_pkg::COORD_WIDTH_DEF
) (
    input  logic                                                     clk,
    input  logic                                                     rst_n,
    input  logic                                                     en,
    input  apt_pkg::front_t                                          front,
    input  logic signed [apt_pkg::sum_width(COORD_WIDTH, FRAC_BITS)-1:0] sum_x,
    input  logic signed [apt_pkg::sum_width(COORD_WIDTH, FRAC_BITS)-1:0] sum_y,
    input  logic signed [apt_pkg::den_width(COORD_WIDTH)-1:0]        det,
    output apt_pkg::ctl_t                                            ctl_o,
    output logic [apt_pkg::den_width(COORD_WIDTH)-1:0]               den_o,
    output logic [apt_pkg::rem_width(COORD_WIDTH, FRAC_BITS)-1:0]    rem_x_o,
    output logic [apt_pkg::rem_width(COORD_WIDTH, FRAC_BITS)-1:0]    rem_y_o,
    output logic [COORD_WIDTH:0]                                     q_x_o,
    output logic [COORD_WIDTH:0]                                     q_y_o
);

    localparam int W  = COORD_WIDTH;
    localparam int SW = apt_pkg::sum_width(W, FRAC_BITS);
    localparam int DB = apt_pkg::den_width(W);
    localparam int DW = apt_pkg::rem_width(W, FRAC_BITS);
    localparam logic [SW:0] HALF = (SW + 1)'(1) << (FRAC_BITS - 1);

    // stage 4
    logic          v4_reg, inv4_reg, sing4_reg, negx4_reg, negy4_reg;
    logic [SW-1:0] magx_reg, magy_reg;
    logic [DB-1:0] den4_reg;
    logic          negx_next, negy_next;

    // stage 5
    logic          v5_reg;
    logic [DW-1:0] numx, numy, lim;
    logic [SW:0]   rndx, rndy;
    logic          ovfx_next, ovfy_next;
    logic [DW-1:0] remx_next, remy_next;
    logic [W:0]    qx_next, qy_next;
    logic [DB-1:0] den_next;
    apt_pkg::ctl_t ctl5_reg;
    logic [DB-1:0] den5_reg;
    logic [DW-1:0] remx_reg, remy_reg;
    logic [W:0]    qx_reg, qy_reg;

    assign negx_next = front.inv ? (sum_x[SW-1] ^ det[DB-1]) : sum_x[SW-1];
    assign negy_next = front.inv ? (sum_y[SW-1] ^ det[DB-1]) : sum_y[SW-1];

    always_comb
    begin
        numx = DW'(magx_reg) << (FRAC_BITS + 1);
        numy = DW'(magy_reg) << (FRAC_BITS + 1);
        lim  = DW'(den4_reg) << (W + 1);
        rndx = ((SW + 1)'(magx_reg) + HALF) >> FRAC_BITS;
        rndy = ((SW + 1)'(magy_reg) + HALF) >> FRAC_BITS;
        if (inv4_reg)
        begin
            remx_next = numx;
            remy_next = numy;
            qx_next   = '0;
            qy_next   = '0;
            ovfx_next = (numx >= lim);
            ovfy_next = (numy >= lim);
            den_next  = den4_reg;
        end
        else
        begin
            // forward result rides through the divider as q = 2*m
            remx_next = '0;
            remy_next = '0;
            qx_next   = {rndx[W-1:0], 1'b0};
            qy_next   = {rndy[W-1:0], 1'b0};
            ovfx_next = ((rndx >> W) != '0);
            ovfy_next = ((rndy >> W) != '0);
            den_next  = DB'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= front.valid;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inv4_reg        <= front.inv;
            sing4_reg       <= front.inv && (det == '0);
            negx4_reg       <= negx_next;
            negy4_reg       <= negy_next;
            magx_reg        <= sum_x[SW-1] ? SW'(-sum_x) : SW'(sum_x);
            magy_reg        <= sum_y[SW-1] ? SW'(-sum_y) : SW'(sum_y);
            den4_reg        <= det[DB-1] ? DB'(-det) : DB'(det);
            ctl5_reg.valid  <= v4_reg;
            ctl5_reg.singular <= sing4_reg;
            ctl5_reg.neg_x  <= negx4_reg;
            ctl5_reg.neg_y  <= negy4_reg;
            ctl5_reg.ovf_x  <= ovfx_next;
            ctl5_reg.ovf_y  <= ovfy_next;
            den5_reg        <= den_next;
            remx_reg        <= remx_next;
            remy_reg        <= remy_next;
            qx_reg          <= qx_next;
            qy_reg          <= qy_next;
        end
    end

    always_comb
    begin
        ctl_o       = ctl5_reg;
        ctl_o.valid = v5_reg;
    end

    assign den_o   = den5_reg;
    assign rem_x_o = remx_reg;
    assign rem_y_o = remy_reg;
    assign q_x_o   = qx_reg;
    assign q_y_o   = qy_reg;

endmodule

// ----- hw/rtl/apt_div_step.sv -----
// One restoring division step for both lanes, quotient bit STEP.
module apt_div_step #(
    parameter int FRAC_BITS   = apt_pkg::FRAC_BITS_DEF,
    parameter int COORD_WIDTH = apt_pkg::COORD_WIDTH_DEF,
    parameter int STEP        = 0
) (
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  logic                                                  en,
    input  apt_pkg::ctl_t                                         ctl_i,
    input  logic [apt_pkg::den_width(COORD_WIDTH)-1:0]            den_i,
    input  logic [apt_pkg::rem_width(COORD_WIDTH, FRAC_BITS)-1:0] rem_x_i,
    input  logic [apt_pkg::rem_width(COORD_WIDTH, FRAC_BITS)-1:0] rem_y_i,
    input  logic [COORD_WIDTH:0]                                  q_x_i,
    input  logic [COORD_WIDTH:0]                                  q_y_i,
    output apt_pkg::ctl_t                                         ctl_o,
    output logic [apt_pkg::den_width(COORD_WIDTH)-1:0]            den_o,
    output logic [apt_pkg::rem_width(COORD_WIDTH, FRAC_BITS)-1:0] rem_x_o,
    output logic [apt_pkg::rem_width(COORD_WIDTH, FRAC_BITS)-1:0] rem_y_o,
    output logic [COORD_WIDTH:0]                                  q_x_o,
    output logic [COORD_WIDTH:0]                                  q_y_o
);

    localparam int W  = COORD_WIDTH;
    localparam int DB = apt_pkg::den_width(W);
    localparam int DW = apt_pkg::rem_width(W, FRAC_BITS);

    logic [DW-1:0] trial;
    logic          hit_x, hit_y;
    logic [DW-1:0] remx_next, remy_next;
    logic [W:0]    qx_next, qy_next;
    logic          valid_reg;
    apt_pkg::ctl_t ctl_reg;
    logic [DB-1:0] den_reg;
    logic [DW-1:0] remx_reg, remy_reg;
    logic [W:0]    qx_reg, qy_reg;

    assign trial = DW'(den_i) << STEP;
    assign hit_x = (rem_x_i >= trial);
    assign hit_y = (rem_y_i >= trial);

    always_comb
    begin
        remx_next       = hit_x ? rem_x_i - trial : rem_x_i;
        remy_next       = hit_y ? rem_y_i - trial : rem_y_i;
        qx_next         = q_x_i;
        qy_next         = q_y_i;
        qx_next[STEP]   = q_x_i[STEP] | hit_x;
        qy_next[STEP]   = q_y_i[STEP] | hit_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= ctl_i.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg  <= ctl_i;
            den_reg  <= den_i;
            remx_reg <= remx_next;
            remy_reg <= remy_next;
            qx_reg   <= qx_next;
            qy_reg   <= qy_next;
        end
    end

    always_comb
    begin
        ctl_o       = ctl_reg;
        ctl_o.valid = valid_reg;
    end

    assign den_o   = den_reg;
    assign rem_x_o = remx_reg;
    assign rem_y_o = remy_reg;
    assign q_x_o   = qx_reg;
    assign q_y_o   = qy_reg;

endmodule

// ----- hw/rtl/apt_finish.sv -----
// Final stage: round the doubled quotient, clamp, sign, zero singular words, output register.
module apt_finish #(
    parameter int COORD_WIDTH = apt_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  apt_pkg::ctl_t                 ctl_i,
    input  logic [COORD_WIDTH:0]          q_x_i,
    input  logic [COORD_WIDTH:0]          q_y_i,
    output logic                          out_valid,
    output logic signed [COORD_WIDTH-1:0] x_out,
    output logic signed [COORD_WIDTH-1:0] y_out,
    output logic [1:0]                    status
);

    localparam int W = COORD_WIDTH;
    localparam logic [W:0]   Q_LIM_NEG = (W + 1)'(1) << W | (W + 1)'(1);
    localparam logic [W:0]   Q_LIM_POS = ((W + 1)'(1) << W) - (W + 1)'(1);
    localparam logic [W-1:0] MIN_V     = W'(1) << (W - 1);
    localparam logic [W-1:0] MAX_V     = ~MIN_V;

    logic [W+1:0]  rnd_x, rnd_y;
    logic [W-1:0]  mag_x, mag_y;
    logic          sat_x, sat_y;
    logic [W-1:0]  vx, vy;
    logic [W-1:0]  x_next, y_next;
    logic [1:0]    st_next;
    logic          valid_reg;
    logic [W-1:0]  x_reg, y_reg;
    logic [1:0]    st_reg;

    always_comb
    begin
        rnd_x = (W + 2)'(q_x_i) + (W + 2)'(1);
        rnd_y = (W + 2)'(q_y_i) + (W + 2)'(1);
        mag_x = rnd_x[W:1];
        mag_y = rnd_y[W:1];
        sat_x = ctl_i.ovf_x || (ctl_i.neg_x ? (q_x_i >= Q_LIM_NEG) : (q_x_i >= Q_LIM_POS));
        sat_y = ctl_i.ovf_y || (ctl_i.neg_y ? (q_y_i >= Q_LIM_NEG) : (q_y_i >= Q_LIM_POS));
        if (sat_x)
            vx = ctl_i.neg_x ? MIN_V : MAX_V;
        else
            vx = ctl_i.neg_x ? -mag_x : mag_x;
        if (sat_y)
            vy = ctl_i.neg_y ? MIN_V : MAX_V;
        else
            vy = ctl_i.neg_y ? -mag_y : mag_y;
        if (ctl_i.singular)
        begin
            x_next  = '0;
            y_next  = '0;
            st_next = apt_pkg::ST_SINGULAR;
        end
        else
        begin
            x_next  = vx;
            y_next  = vy;
            st_next = (sat_x || sat_y) ? apt_pkg::ST_SAT : apt_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= ctl_i.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg  <= x_next;
            y_reg  <= y_next;
            st_reg <= st_next;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign status    = st_reg;

endmodule

// ----- hw/rtl/apt_checker.sv -----
`include "affine_point_transform_core_macros.svh"

module apt_checker #(
    parameter int COORD_WIDTH = apt_pkg::COORD_WIDTH_DEF
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_stall,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic [COORD_WIDTH-1:0] x_out,
    input logic [COORD_WIDTH-1:0] y_out,
    input logic [1:0]             status
);

    localparam logic [COORD_WIDTH-1:0] MIN_V = COORD_WIDTH'(1) << (COORD_WIDTH - 1);
    localparam logic [COORD_WIDTH-1:0] MAX_V = ~MIN_V;

    // a stalled word stays on the port
    `APT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(x_out) && $stable(y_out) && $stable(status), "stalled result word changed")

    // input only backs up behind a stalled result
    `APT_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without output stall")

    // singular inverse reports a zero point
    `APT_ASSERT_NOW(a_singular_zero, out_valid && (status == apt_pkg::ST_SINGULAR), (x_out == '0) && (y_out == '0), "singular word with nonzero point")

    // a saturated word has at least one coordinate at a range end
    `APT_ASSERT_NOW(a_sat_clamped, out_valid && (status == apt_pkg::ST_SAT), (x_out == MIN_V) || (x_out == MAX_V) || (y_out == MIN_V) || (y_out == MAX_V), "saturated word not clamped")

endmodule

bind affine_point_transform_core apt_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_apt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .x_out     (x_out),
    .y_out     (y_out),
    .status    (status)
);
